[rtl/schedule_table_engine_assert.svh]
// Assertion macros shared by the schedule table engine RTL.
`ifndef SCHEDULE_TABLE_ENGINE_ASSERT_SVH
`define SCHEDULE_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("schedule table engine assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("schedule table engine assertion failed");

`endif

[rtl/ste_pkg.sv]
// Shared types and constants of the schedule table engine.
`default_nettype none

package ste_pkg;

	localparam int RESULT_CAP = 16;
	localparam int CAP_W      = 5;
	localparam int IDX_W      = 4;

	typedef enum logic [2:0] {
		OP_TICK        = 3'd0,
		OP_START_REL   = 3'd1,
		OP_START_ABS   = 3'd2,
		OP_STOP        = 3'd3,
		OP_WRITE_POINT = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK          = 2'd0,
		ERR_BAD_VALUE   = 2'd1,
		ERR_WRONG_STATE = 2'd2,
		ERR_STOPPED     = 2'd3
	} err_t;

	localparam logic [2:0] CFG_COUNTER_MAX    = 3'd0;
	localparam logic [2:0] CFG_TABLE_DURATION = 3'd1;
	localparam logic [2:0] CFG_REPEAT_MODE    = 3'd2;
	localparam logic [2:0] CFG_POINT_COUNT    = 3'd3;

	typedef struct packed {
		logic invert_b;
		logic carry_in;
	} alu_ctl_t;

	localparam alu_ctl_t ALU_ADD  = '{invert_b: 1'b0, carry_in: 1'b0};
	localparam alu_ctl_t ALU_ADD1 = '{invert_b: 1'b0, carry_in: 1'b1};
	localparam alu_ctl_t ALU_SUB  = '{invert_b: 1'b1, carry_in: 1'b1};

endpackage

`default_nettype wire

[rtl/ste_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ste_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/ste_alu.sv]
// Shared add/subtract unit with carry and zero flags.
`default_nettype none

module ste_alu
	import ste_pkg::*;
#(
	parameter int W = 32
) (
	input  wire logic     [W-1:0] a,
	input  wire logic     [W-1:0] b,
	input  wire alu_ctl_t         ctl,
	output logic          [W-1:0] sum,
	output logic                  carry,
	output logic                  zero
);

	logic [W-1:0] b_eff;
	logic [W:0]   full;

	assign b_eff = ctl.invert_b ? ~b : b;
	assign full  = {1'b0, a} + {1'b0, b_eff} + (W+1)'(ctl.carry_in);
	assign sum   = full[W-1:0];
	assign carry = full[W];
	assign zero  = (full[W-1:0] == '0);

endmodule

`default_nettype wire

[rtl/schedule_table_engine.sv]
// Top level of the counter-driven schedule table engine.
//
// Input channel (in_valid/in_stall) takes one op per transaction: tick, relative
// start, absolute start, stop or expiry-point write. Output channel
// (out_valid/out_stall) returns one or more result transactions per op; the
// final one has last set. Configuration is a separate valid/ready write port,
// always ready. The user must write it only while the engine is idle; the
// block itself does not enforce this. One op is handled at a time; in_stall is
// high from acceptance until the final result is registered. Each op steps
// through the single shared adder and the single read port of the point memory:
//   stop, write, unknown op, tick while stopped: straight to the result
//   absolute start: A1, A2, A3 and, if needed, A4; relative start: R1, R2
//   tick during start delay: T1; once it expires, also the point checks
//   tick after delay: T1, optional T2, T3, a read and compare per point checked
// A stalled receiver holds the output register; the engine waits with it.
// Reset clears the run state and the output valid; configuration registers go
// to defaults. Point offsets are not cleared and must be written before use.
`default_nettype none
`include "schedule_table_engine_assert.svh"

module schedule_table_engine
	import ste_pkg::*;
#(
	parameter int MAX_POINTS = 16,
	parameter int TICK_BITS  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [31:0] operand_value,
	input  wire logic [31:0] counter_now,
	input  wire logic [3:0]  point_slot,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             fired,
	output logic [IDX_W-1:0] point_index,
	output logic             last,
	output logic             proceed,
	output logic             running,
	output logic [1:0]       error_code
);

	localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int PCW = ($clog2(MAX_POINTS + 1) > CAP_W) ? $clog2(MAX_POINTS + 1) : CAP_W;
	localparam int TW  = TICK_BITS;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_R1    = 13'b0000000000010,
		S_R2    = 13'b0000000000100,
		S_A1    = 13'b0000000001000,
		S_A2    = 13'b0000000010000,
		S_A3    = 13'b0000000100000,
		S_A4    = 13'b0000001000000,
		S_T1    = 13'b0000010000000,
		S_T2    = 13'b0000100000000,
		S_T3    = 13'b0001000000000,
		S_F_RD  = 13'b0010000000000,
		S_F_CMP = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t            state_q;
	logic [TW-1:0]     counter_max_q;
	logic [TW-1:0]     table_duration_q;
	logic              repeat_mode_q;
	logic [4:0]        point_count_q;
	logic              run_q;
	logic [TW-1:0]     delay_q;
	logic [TW-1:0]     table_tick_q;
	logic [PW-1:0]     np_q;
	logic [CAP_W-1:0]  n_q;
	logic              pend_q;
	logic              out_valid_q;

	logic [TW-1:0]     val_q;
	logic [TW-1:0]     now_q;
	logic [TW-1:0]     acc_q;
	logic              bad_q;
	logic              ge_q;
	err_t              err_q;
	logic              proceed_q;
	logic [PW-1:0]     pend_idx_q;
	logic              fired_q;
	logic [IDX_W-1:0]  point_index_q;
	logic              last_q;
	logic              proceed_out_q;
	logic              running_q;
	err_t              error_code_q;

	op_t               op_in;
	logic              in_acc;
	logic              out_free;
	logic              push_mid;
	logic              push_fin;
	logic [PCW-1:0]    pc0;
	logic [PCW-1:0]    pc;
	logic [CAP_W-1:0]  cap;
	logic [CAP_W-1:0]  n_inc;
	logic [PW-1:0]     np_eff;
	logic [PCW-1:0]    np_plus;
	logic [PW-1:0]     np_inc;
	logic              delay_nz;
	logic              rel_bad;
	logic              rel_start;
	logic              abs_fin;
	logic              abs_start;
	logic [TW-1:0]     abs_delay;
	logic              match_take;

	logic [TW-1:0]     alu_a;
	logic [TW-1:0]     alu_b;
	alu_ctl_t          alu_ctl;
	logic [TW-1:0]     alu_sum;
	logic              alu_carry;
	logic              alu_zero;

	logic              ram_we;
	logic              ram_re;
	logic [PW-1:0]     ram_raddr;
	logic [TW-1:0]     ram_rdata;

	assign op_in     = op_t'(op);
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign pc0 = (point_count_q == '0) ? PCW'(1) : PCW'(point_count_q);
	assign pc  = (pc0 > PCW'(MAX_POINTS)) ? PCW'(MAX_POINTS) : pc0;
	assign cap = (pc < PCW'(RESULT_CAP)) ? CAP_W'(pc) : CAP_W'(RESULT_CAP);
	assign n_inc = n_q + CAP_W'(1);

	assign np_eff  = (PCW'(np_q) >= pc) ? '0 : np_q;
	assign np_plus = PCW'(np_q) + PCW'(1);
	assign np_inc  = (np_plus >= pc) ? '0 : PW'(np_plus);

	assign delay_nz   = (delay_q != '0);
	assign rel_bad    = bad_q || !alu_carry;
	assign rel_start  = (state_q == S_R2) && !rel_bad && !run_q;
	assign abs_fin    = ((state_q == S_A3) && ge_q) || (state_q == S_A4);
	assign abs_start  = abs_fin && !bad_q && !run_q;
	assign abs_delay  = (state_q == S_A4) ? alu_sum : acc_q;
	assign match_take = (state_q == S_F_CMP) && alu_zero && (!pend_q || out_free);

	assign push_mid = (state_q == S_F_CMP) && alu_zero && pend_q && out_free;
	assign push_fin = (state_q == S_DONE) && out_free;

	always_comb begin
		alu_a   = acc_q;
		alu_b   = val_q;
		alu_ctl = ALU_ADD;
		case (state_q)
			S_R1: begin
				alu_a   = counter_max_q;
				alu_b   = ram_rdata;
				alu_ctl = ALU_SUB;
			end
			S_R2: begin
				alu_a   = acc_q;
				alu_b   = val_q;
				alu_ctl = ALU_SUB;
			end
			S_A1: begin
				alu_a   = counter_max_q;
				alu_b   = val_q;
				alu_ctl = ALU_SUB;
			end
			S_A2: begin
				alu_a   = val_q;
				alu_b   = now_q;
				alu_ctl = ALU_SUB;
			end
			S_A3: begin
				alu_a   = counter_max_q;
				alu_b   = now_q;
				alu_ctl = ALU_SUB;
			end
			S_A4: begin
				alu_a   = acc_q;
				alu_b   = val_q;
				alu_ctl = ALU_ADD1;
			end
			S_T1: begin
				alu_ctl = ALU_SUB;
				if (delay_nz) begin
					alu_a = delay_q;
					alu_b = TW'(1);
				end else begin
					alu_a = table_tick_q;
					alu_b = table_duration_q;
				end
			end
			S_T2: begin
				alu_a   = table_tick_q;
				alu_b   = TW'(1);
				alu_ctl = ALU_ADD;
			end
			S_T3: begin
				alu_a   = table_tick_q;
				alu_b   = table_duration_q;
				alu_ctl = ALU_SUB;
			end
			S_F_CMP: begin
				alu_a   = table_tick_q;
				alu_b   = ram_rdata;
				alu_ctl = ALU_SUB;
			end
			default: begin
				alu_a   = acc_q;
				alu_b   = val_q;
				alu_ctl = ALU_ADD;
			end
		endcase
	end

	ste_alu #(
		.W(TW)
	) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.ctl  (alu_ctl),
		.sum  (alu_sum),
		.carry(alu_carry),
		.zero (alu_zero)
	);

	assign ram_we    = in_acc && (op_in == OP_WRITE_POINT) && (32'(point_slot) < MAX_POINTS);
	assign ram_re    = (in_acc && (op_in == OP_START_REL)) || (state_q == S_F_RD);
	assign ram_raddr = (state_q == S_F_RD) ? np_eff : '0;

	ste_ram #(
		.WIDTH(TW),
		.DEPTH(MAX_POINTS)
	) u_points (
		.clk  (clk),
		.we   (ram_we),
		.waddr(PW'(point_slot)),
		.wdata(TW'(operand_value)),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			counter_max_q    <= TW'(32'hFFFF_FFFF);
			table_duration_q <= TW'(1);
			repeat_mode_q    <= 1'b0;
			point_count_q    <= 5'd1;
			run_q            <= 1'b0;
			delay_q          <= '0;
			table_tick_q     <= '0;
			np_q             <= '0;
			n_q              <= '0;
			pend_q           <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_COUNTER_MAX:    counter_max_q    <= TW'(cfg_data);
					CFG_TABLE_DURATION: table_duration_q <= TW'(cfg_data);
					CFG_REPEAT_MODE:    repeat_mode_q    <= cfg_data[0];
					CFG_POINT_COUNT:    point_count_q    <= cfg_data[4:0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						n_q    <= '0;
						pend_q <= 1'b0;
						case (op_in)
							OP_TICK:      state_q <= run_q ? S_T1 : S_DONE;
							OP_START_REL: state_q <= S_R1;
							OP_START_ABS: state_q <= S_A1;
							OP_STOP: begin
								run_q   <= 1'b0;
								state_q <= S_DONE;
							end
							default:      state_q <= S_DONE;
						endcase
					end
				end
				S_R1: state_q <= S_R2;
				S_R2: begin
					if (rel_start) begin
						delay_q      <= val_q;
						table_tick_q <= '0;
						np_q         <= '0;
						run_q        <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_A1: state_q <= S_A2;
				S_A2: state_q <= S_A3;
				S_A3: state_q <= ge_q ? S_DONE : S_A4;
				S_A4: state_q <= S_DONE;
				S_T1: begin
					if (delay_nz) begin
						delay_q <= alu_sum;
						state_q <= alu_zero ? S_F_RD : S_DONE;
					end else begin
						state_q <= alu_carry ? S_T3 : S_T2;
					end
				end
				S_T2: begin
					table_tick_q <= alu_sum;
					state_q      <= S_T3;
				end
				S_T3: begin
					if (alu_zero) begin
						if (repeat_mode_q) begin
							table_tick_q <= '0;
						end else begin
							run_q <= 1'b0;
						end
					end
					state_q <= S_F_RD;
				end
				S_F_RD: begin
					np_q    <= np_eff;
					state_q <= S_F_CMP;
				end
				S_F_CMP: begin
					if (!alu_zero) begin
						state_q <= S_DONE;
					end else if (match_take) begin
						pend_q  <= 1'b1;
						n_q     <= n_inc;
						np_q    <= np_inc;
						state_q <= (n_inc == cap) ? S_DONE : S_F_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (abs_start) begin
				delay_q      <= abs_delay;
				table_tick_q <= '0;
				np_q         <= '0;
				run_q        <= 1'b1;
			end

			if (push_mid || push_fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					val_q <= TW'(operand_value);
					now_q <= TW'(counter_now);
					case (op_in)
						OP_TICK: begin
							err_q     <= ERR_OK;
							proceed_q <= 1'b0;
						end
						OP_STOP: begin
							err_q     <= run_q ? ERR_OK : ERR_STOPPED;
							proceed_q <= 1'b0;
						end
						OP_WRITE_POINT: begin
							err_q     <= ERR_OK;
							proceed_q <= run_q;
						end
						OP_START_REL, OP_START_ABS: begin
							err_q     <= ERR_OK;
							proceed_q <= run_q;
						end
						default: begin
							err_q     <= ERR_BAD_VALUE;
							proceed_q <= run_q;
						end
					endcase
				end
			end
			S_R1: begin
				acc_q <= alu_sum;
				bad_q <= (val_q == '0) || !alu_carry;
			end
			S_R2: begin
				err_q     <= rel_bad ? ERR_BAD_VALUE : (run_q ? ERR_WRONG_STATE : ERR_OK);
				proceed_q <= rel_bad ? run_q : 1'b1;
			end
			S_A1: bad_q <= !alu_carry;
			S_A2: begin
				acc_q <= alu_sum;
				ge_q  <= alu_carry;
			end
			S_A3: begin
				if (!ge_q) begin
					acc_q <= alu_sum;
				end
			end
			S_T1: proceed_q <= 1'b1;
			S_T3: begin
				if (alu_zero && !repeat_mode_q) begin
					proceed_q <= 1'b0;
				end
			end
			S_F_CMP: begin
				if (match_take) begin
					pend_idx_q <= np_q;
				end
			end
			default: ;
		endcase

		if (abs_fin) begin
			err_q     <= bad_q ? ERR_BAD_VALUE : (run_q ? ERR_WRONG_STATE : ERR_OK);
			proceed_q <= bad_q ? run_q : 1'b1;
		end

		if (push_mid) begin
			fired_q       <= 1'b1;
			point_index_q <= IDX_W'(pend_idx_q);
			last_q        <= 1'b0;
			proceed_out_q <= proceed_q;
			running_q     <= run_q;
			error_code_q  <= err_q;
		end else if (push_fin) begin
			fired_q       <= pend_q;
			point_index_q <= pend_q ? IDX_W'(pend_idx_q) : '0;
			last_q        <= 1'b1;
			proceed_out_q <= proceed_q;
			running_q     <= run_q;
			error_code_q  <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign fired       = fired_q;
	assign point_index = point_index_q;
	assign last        = last_q;
	assign proceed     = proceed_out_q;
	assign running     = running_q;
	assign error_code  = error_code_q;

	`STE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, state_q != S_IDLE)
	`STE_ASSERT_IMPLY(a_fire_no_error, clk, arst_n, out_valid && fired, error_code == ERR_OK)
	`STE_ASSERT_IMPLY(a_fire_under_cap, clk, arst_n, state_q == S_F_CMP, n_q < cap)
	`STE_ASSERT_IMPLY(a_start_clears, clk, arst_n, $rose(run_q), table_tick_q == '0 && np_q == '0)

endmodule

`default_nettype wire
